// File: src/nsab_pkg.sv
package nsab_pkg;

   // Pixel channel geometry.
   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
   localparam int CHANNELS = 3;
   localparam int SRC_WORD_W = 4 * PIX_W;

   // Field widths of the request and response items.
   localparam int COORD_W = 10;
   localparam int LOAD_IDX_W = 12;
   localparam int POS_W = 12;
   localparam int SIZE_W = 7;
   localparam int AREA_W = 11;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   // Nearest-neighbor index division: numerator is coordinate times source size.
   localparam int QUOT_BITS = SIZE_W;
   localparam int NUM_W = COORD_W + SIZE_W;
   localparam int DEN_W = AREA_W;

   // Source address arithmetic.
   localparam int ADDR_FULL_W = 2 * SIZE_W;
   localparam int ADDR_CMP_W = 17;

   // Blend arithmetic: s*a + d*(255-a) fits in 16 bits.
   localparam int BLEND_W = 2 * PIX_W;

   // Response queue.
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Register port.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAW_WIDTH    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAW_HEIGHT   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X      = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y      = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WIDTH  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_HEIGHT = 4'd7;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_DRAW = 1'b1
   } op_type;

   typedef struct packed {
      logic             write_valid;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [POS_W-1:0] target_row;
      logic [POS_W-1:0] target_col;
   } rsp_item_type;

endpackage

// File: src/nsab_divider.sv
// Pipelined restoring divider, one quotient bit per stage, most significant first.
// The quotient is exact whenever it fits in QUOT_BITS bits.
module nsab_divider import nsab_pkg::*; (
   input  logic                 clock,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [QUOT_BITS-1:0] quo
);

   logic [NUM_W-1:0]     rem_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quo_ff   [QUOT_BITS];
   logic [NUM_W-1:0]     rem_in   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quo_in   [QUOT_BITS];
   logic [NUM_W-1:0]     stage_rem [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] stage_quo [QUOT_BITS+1];
   logic [NUM_W:0]       den_shift [QUOT_BITS];
   logic [NUM_W:0]       diff      [QUOT_BITS];

   always_comb begin
      stage_rem[0] = num;
      stage_quo[0] = '0;
      for (int k = 0; k < QUOT_BITS; k++) begin
         stage_rem[k+1] = rem_ff[k];
         stage_quo[k+1] = quo_ff[k];
      end
      for (int k = 0; k < QUOT_BITS; k++) begin
         den_shift[k] = (NUM_W+1)'(den) << (QUOT_BITS - 1 - k);
         diff[k]      = {1'b0, stage_rem[k]} - den_shift[k];
         // A clear borrow bit means the shifted divisor fits into the remainder.
         rem_in[k]    = diff[k][NUM_W] ? stage_rem[k] : diff[k][NUM_W-1:0];
         quo_in[k]    = stage_quo[k];
         quo_in[k][QUOT_BITS-1-k] = ~diff[k][NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUOT_BITS; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo = quo_ff[QUOT_BITS-1];

endmodule

// File: src/nsab_blend.sv
// Alpha-over blend of three channels: (s*a + d*(255-a)) / 255, truncated.
// The weighted sums are registered; the division by 255 follows the register.
module nsab_blend import nsab_pkg::*; (
   input  logic                  clock,
   input  logic [SRC_WORD_W-1:0] src_pixel,
   input  logic [PIX_W-1:0]      dst_red,
   input  logic [PIX_W-1:0]      dst_green,
   input  logic [PIX_W-1:0]      dst_blue,
   output logic [PIX_W-1:0]      out_red,
   output logic [PIX_W-1:0]      out_green,
   output logic [PIX_W-1:0]      out_blue
);

   logic [PIX_W-1:0]   alpha;
   logic [PIX_W-1:0]   inv_alpha;
   logic [PIX_W-1:0]   dst       [CHANNELS];
   logic [BLEND_W-1:0] sum_in    [CHANNELS];
   logic [BLEND_W-1:0] sum_ff    [CHANNELS];
   logic [BLEND_W:0]   rounded   [CHANNELS];
   logic [PIX_W-1:0]   quo       [CHANNELS];

   always_comb begin
      alpha     = src_pixel[SRC_WORD_W-1 -: PIX_W];
      inv_alpha = PIX_MAX - alpha;
      dst[0]    = dst_red;
      dst[1]    = dst_green;
      dst[2]    = dst_blue;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_in[c] = BLEND_W'(src_pixel[c*PIX_W +: PIX_W]) * BLEND_W'(alpha)
                   + BLEND_W'(dst[c]) * BLEND_W'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum_ff[c] <= sum_in[c];
      end
   end

   // floor(x / 255) equals (x + (x >> 8) + 1) >> 8 over the whole range of the sum.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         rounded[c] = (BLEND_W+1)'(sum_ff[c]) + (BLEND_W+1)'(sum_ff[c] >> PIX_W)
                    + (BLEND_W+1)'(1);
         quo[c]     = rounded[c][2*PIX_W-1:PIX_W];
      end
   end

   assign out_red   = quo[0];
   assign out_green = quo[1];
   assign out_blue  = quo[2];

endmodule

// File: src/nsab_fifo.sv
// Response queue. Space is reserved upstream, so a push never meets a full queue.
module nsab_fifo import nsab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_item_type          push_item,
   input  logic                  pop,
   output rsp_item_type          pop_item,
   output logic [FIFO_CNT_W-1:0] count
);

   rsp_item_type          entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

// File: src/nearest_scaled_alpha_blit.sv
// Nearest-neighbor scaled blit with alpha-over blending.
// The req_ channel carries load and draw items, selected by req_tuser. A load writes one
// RGBA source pixel into the source store and returns nothing. A draw names a position
// inside the drawing area plus the current destination color and returns exactly one
// item on the rsp_ channel: rsp_tuser high with the target position and blended color
// when the pixel must be replaced, or rsp_tuser low with all data zero when it is not.
// The csr_ channel writes the eight geometry registers; it is always ready, and writes
// are meant to happen only while no draw is in flight.
// Throughput is one item per clock while req_tready is high. On its way to rsp_tvalid a
// draw passes the seven-stage divider that finds the source column and row, followed by
// the address multiply, the store read and the blend.
// Results queue in a 16-entry response FIFO. Space is reserved when a draw is accepted,
// so req_tready drops only once 16 draws are accepted and not yet transferred out; a
// stalled receiver therefore backs up into the queue and then the request side.
// Reset is synchronous and restores the register defaults and empties the pipeline and
// the queue. The source store is not cleared: entries must be loaded before drawn.
module nearest_scaled_alpha_blit import nsab_pkg::*; #(
   parameter int SOURCE_PIXELS = 4096,
   parameter int COORD_BITS    = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: load_index[11:0], draw_col[9:0], draw_row[9:0], pixel_red[7:0],
   // pixel_green[7:0], pixel_blue[7:0], pixel_alpha[7:0].
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: operation (0 load, 1 draw).
   input  logic                   req_tuser,
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata from bit 0: target_col[11:0], target_row[11:0], out_red[7:0],
   // out_green[7:0], out_blue[7:0], out_alpha[7:0].
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: write_valid.
   output logic                   rsp_tuser,
   // Register write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(SOURCE_PIXELS);
   localparam logic [ADDR_CMP_W-1:0] PIXELS_LIMIT = ADDR_CMP_W'(SOURCE_PIXELS);
   localparam logic [COORD_W-1:0] COL_MASK =
      (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

   // Sideband that travels alongside the divider.
   typedef struct packed {
      op_type                 op;
      logic [LOAD_IDX_W-1:0]  load_index;
      logic                   in_range;
      logic [POS_W-1:0]       tx;
      logic [POS_W-1:0]       ty;
      logic [PIX_W-1:0]       red;
      logic [PIX_W-1:0]       green;
      logic [PIX_W-1:0]       blue;
      logic [PIX_W-1:0]       alpha;
   } side_type;

   // ---------------------------------------------------------------------------------
   // Geometry registers.
   // ---------------------------------------------------------------------------------
   logic [SIZE_W-1:0] src_width_ff;
   logic [SIZE_W-1:0] src_height_ff;
   logic [AREA_W-1:0] draw_width_ff;
   logic [AREA_W-1:0] draw_height_ff;
   logic [POS_W-1:0]  origin_x_ff;
   logic [POS_W-1:0]  origin_y_ff;
   logic [AREA_W-1:0] target_width_ff;
   logic [AREA_W-1:0] target_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= SIZE_W'(32);
         src_height_ff    <= SIZE_W'(32);
         draw_width_ff    <= AREA_W'(28);
         draw_height_ff   <= AREA_W'(28);
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         target_width_ff  <= AREA_W'(288);
         target_height_ff <= AREA_W'(32);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_width_ff     <= csr_data[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: src_height_ff    <= csr_data[SIZE_W-1:0];
            CSR_DRAW_WIDTH:    draw_width_ff    <= csr_data[AREA_W-1:0];
            CSR_DRAW_HEIGHT:   draw_height_ff   <= csr_data[AREA_W-1:0];
            CSR_ORIGIN_X:      origin_x_ff      <= csr_data[POS_W-1:0];
            CSR_ORIGIN_Y:      origin_y_ff      <= csr_data[POS_W-1:0];
            CSR_TARGET_WIDTH:  target_width_ff  <= csr_data[AREA_W-1:0];
            CSR_TARGET_HEIGHT: target_height_ff <= csr_data[AREA_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Space reservation in the response queue.
   // ---------------------------------------------------------------------------------
   logic                  req_fire;
   logic                  draw_fire;
   logic                  rsp_fire;
   logic [FIFO_CNT_W-1:0] used_ff;
   logic [FIFO_CNT_W-1:0] used_in;
   logic [FIFO_CNT_W-1:0] fifo_count;

   assign req_tready = (used_ff < FIFO_CNT_W'(FIFO_DEPTH));
   assign req_fire   = req_tvalid && req_tready;
   assign draw_fire  = req_fire && (op_type'(req_tuser) == OP_DRAW);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      used_in = used_ff;
      if (draw_fire && !rsp_fire) begin
         used_in = used_ff + FIFO_CNT_W'(1);
      end else if (rsp_fire && !draw_fire) begin
         used_in = used_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: captured request.
   // ---------------------------------------------------------------------------------
   logic                  s0_valid_ff;
   op_type                s0_op_ff;
   logic [REQ_DATA_W-1:0] s0_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s0_op_ff   <= op_type'(req_tuser);
      s0_data_ff <= req_tdata;
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: area test, placement and clipping, and the two index products.
   // ---------------------------------------------------------------------------------
   logic [COORD_W-1:0] col_m;
   logic [COORD_W-1:0] row_m;
   logic [POS_W:0]     tx_sum;
   logic [POS_W:0]     ty_sum;
   logic               clip_ok;
   logic               area_ok;
   side_type           s1_side_in;
   logic [NUM_W-1:0]   num_x_in;
   logic [NUM_W-1:0]   num_y_in;

   logic               s1_valid_ff;
   side_type           s1_side_ff;
   logic [NUM_W-1:0]   num_x_ff;
   logic [NUM_W-1:0]   num_y_ff;

   always_comb begin
      col_m  = s0_data_ff[21:12] & COL_MASK;
      row_m  = s0_data_ff[31:22] & COL_MASK;
      // Target position in one extra bit so a negative origin stays visible.
      tx_sum = {origin_x_ff[POS_W-1], origin_x_ff} + (POS_W+1)'(col_m);
      ty_sum = {origin_y_ff[POS_W-1], origin_y_ff} + (POS_W+1)'(row_m);
      clip_ok = !tx_sum[POS_W] && !ty_sum[POS_W]
             && (tx_sum[POS_W-1:0] < POS_W'(target_width_ff))
             && (ty_sum[POS_W-1:0] < POS_W'(target_height_ff));
      area_ok = (AREA_W'(col_m) < draw_width_ff) && (AREA_W'(row_m) < draw_height_ff)
             && (src_width_ff != '0) && (src_height_ff != '0);

      s1_side_in.op         = s0_op_ff;
      s1_side_in.load_index = s0_data_ff[11:0];
      s1_side_in.in_range   = area_ok && clip_ok;
      s1_side_in.tx         = tx_sum[POS_W-1:0];
      s1_side_in.ty         = ty_sum[POS_W-1:0];
      s1_side_in.red        = s0_data_ff[39:32];
      s1_side_in.green      = s0_data_ff[47:40];
      s1_side_in.blue       = s0_data_ff[55:48];
      s1_side_in.alpha      = s0_data_ff[63:56];

      num_x_in = NUM_W'(col_m) * NUM_W'(src_width_ff);
      num_y_in = NUM_W'(row_m) * NUM_W'(src_height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= s1_side_in;
      num_x_ff   <= num_x_in;
      num_y_ff   <= num_y_in;
   end

   // ---------------------------------------------------------------------------------
   // Divider stages: source column and row. Inside the drawing area the quotient is
   // below the source size, so seven quotient bits are enough.
   // ---------------------------------------------------------------------------------
   logic [QUOT_BITS-1:0] src_x;
   logic [QUOT_BITS-1:0] src_y;
   logic [QUOT_BITS-1:0] dly_valid_ff;
   side_type             dly_side_ff [QUOT_BITS];

   nsab_divider u_div_x (
      .clock (clock),
      .num   (num_x_ff),
      .den   (draw_width_ff),
      .quo   (src_x)
   );

   nsab_divider u_div_y (
      .clock (clock),
      .num   (num_y_ff),
      .den   (draw_height_ff),
      .quo   (src_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_valid_ff <= '0;
      end else begin
         dly_valid_ff <= {dly_valid_ff[QUOT_BITS-2:0], s1_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      dly_side_ff[0] <= s1_side_ff;
      for (int k = 1; k < QUOT_BITS; k++) begin
         dly_side_ff[k] <= dly_side_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: store address. Loads use their own index; draws use row*width+column.
   // ---------------------------------------------------------------------------------
   side_type               div_side;
   logic [ADDR_FULL_W-1:0] addr_full;
   logic [ADDR_W-1:0]      s2_addr_in;
   logic                   s2_addr_ok_in;

   logic                   s2_valid_ff;
   side_type               s2_side_ff;
   logic [ADDR_W-1:0]      s2_addr_ff;
   logic                   s2_addr_ok_ff;

   always_comb begin
      div_side  = dly_side_ff[QUOT_BITS-1];
      addr_full = ADDR_FULL_W'(src_y) * ADDR_FULL_W'(src_width_ff) + ADDR_FULL_W'(src_x);
      if (div_side.op == OP_LOAD) begin
         s2_addr_in    = ADDR_W'(div_side.load_index);
         s2_addr_ok_in = ADDR_CMP_W'(div_side.load_index) < PIXELS_LIMIT;
      end else begin
         s2_addr_in    = ADDR_W'(addr_full);
         s2_addr_ok_in = ADDR_CMP_W'(addr_full) < PIXELS_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= dly_valid_ff[QUOT_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff    <= div_side;
      s2_addr_ff    <= s2_addr_in;
      s2_addr_ok_ff <= s2_addr_ok_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 3: source store. Loads write and draws read at this one stage, so every
   // access happens in request order and a draw always sees the loads before it.
   // ---------------------------------------------------------------------------------
   logic [SRC_WORD_W-1:0] store_mem [SOURCE_PIXELS];
   logic [SRC_WORD_W-1:0] rd_data_ff;
   logic                  store_write;

   logic                  s3_valid_ff;
   logic                  s3_hit_ff;
   logic [POS_W-1:0]      s3_tx_ff;
   logic [POS_W-1:0]      s3_ty_ff;
   logic [PIX_W-1:0]      s3_red_ff;
   logic [PIX_W-1:0]      s3_green_ff;
   logic [PIX_W-1:0]      s3_blue_ff;

   assign store_write = s2_valid_ff && (s2_side_ff.op == OP_LOAD) && s2_addr_ok_ff;

   always_ff @(posedge clock) begin
      if (store_write) begin
         store_mem[s2_addr_ff] <= {s2_side_ff.alpha, s2_side_ff.blue,
                                   s2_side_ff.green, s2_side_ff.red};
      end
      rd_data_ff <= store_mem[s2_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff && (s2_side_ff.op == OP_DRAW);
      end
   end

   always_ff @(posedge clock) begin
      s3_hit_ff   <= s2_side_ff.in_range && s2_addr_ok_ff;
      s3_tx_ff    <= s2_side_ff.tx;
      s3_ty_ff    <= s2_side_ff.ty;
      s3_red_ff   <= s2_side_ff.red;
      s3_green_ff <= s2_side_ff.green;
      s3_blue_ff  <= s2_side_ff.blue;
   end

   // ---------------------------------------------------------------------------------
   // Stage 4: blend. A transparent source pixel leaves the destination untouched.
   // ---------------------------------------------------------------------------------
   logic             s4_valid_ff;
   logic             s4_write_ff;
   logic             s4_write_in;
   logic [POS_W-1:0] s4_tx_ff;
   logic [POS_W-1:0] s4_ty_ff;
   logic [PIX_W-1:0] blend_red;
   logic [PIX_W-1:0] blend_green;
   logic [PIX_W-1:0] blend_blue;

   assign s4_write_in = s3_hit_ff && (rd_data_ff[SRC_WORD_W-1 -: PIX_W] != '0);

   nsab_blend u_blend (
      .clock     (clock),
      .src_pixel (rd_data_ff),
      .dst_red   (s3_red_ff),
      .dst_green (s3_green_ff),
      .dst_blue  (s3_blue_ff),
      .out_red   (blend_red),
      .out_green (blend_green),
      .out_blue  (blend_blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_write_ff <= s4_write_in;
      s4_tx_ff    <= s3_tx_ff;
      s4_ty_ff    <= s3_ty_ff;
   end

   // ---------------------------------------------------------------------------------
   // Response queue and output packing. A skipped pixel carries all-zero data.
   // ---------------------------------------------------------------------------------
   rsp_item_type push_item;
   rsp_item_type head_item;

   always_comb begin
      push_item = '0;
      if (s4_write_ff) begin
         push_item.write_valid = 1'b1;
         push_item.target_col  = s4_tx_ff;
         push_item.target_row  = s4_ty_ff;
         push_item.red         = blend_red;
         push_item.green       = blend_green;
         push_item.blue        = blend_blue;
      end
   end

   nsab_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_valid_ff),
      .push_item (push_item),
      .pop       (rsp_fire),
      .pop_item  (head_item),
      .count     (fifo_count)
   );

   assign rsp_tvalid = (fifo_count != '0);
   assign rsp_tuser  = head_item.write_valid;
   assign rsp_tdata  = {(head_item.write_valid ? PIX_MAX : PIX_W'(0)),
                        head_item.blue, head_item.green, head_item.red,
                        head_item.target_row, head_item.target_col};

   // ---------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------
   // Reserved space never exceeds the queue, so a push never overruns it.
   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("response reservations exceed the queue depth");

   // Every queued result was reserved when its draw was accepted.
   a_queue_reserved: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= used_ff)
      else $error("response queue holds an unreserved result");

   // An accepted draw without a departing result takes one more reservation.
   a_reserve_take: assert property (@(posedge clock) disable iff (reset)
      draw_fire && !rsp_fire |=> used_ff == $past(used_ff) + FIFO_CNT_W'(1))
      else $error("accepted draw did not reserve queue space");

   // A skipped pixel is delivered with all-zero data.
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("skipped pixel carries nonzero data");

endmodule

// File: tb/sv/tb.sv
module tb;
   import nsab_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int ITEM_TARGET = 1300;
   // Give the block a margin past its pipeline depth.
   localparam int SETTLE_CYCLES = 24;

   // One request item as the block sees it on req_tdata and req_tuser.
   typedef struct packed {
      op_type                op;
      logic [PIX_W-1:0]      alpha;
      logic [PIX_W-1:0]      blue;
      logic [PIX_W-1:0]      green;
      logic [PIX_W-1:0]      red;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
      logic [LOAD_IDX_W-1:0] index;
   } blit_req_type;

   // One destination pixel decision as it leaves on the rsp_ channel.
   typedef struct packed {
      logic             wr;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] alpha;
   } blit_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the geometry registers, starting from the reset defaults.
   logic [SIZE_W-1:0]        src_w = 7'd32;
   logic [SIZE_W-1:0]        src_h = 7'd32;
   logic [AREA_W-1:0]        draw_w = 11'd28;
   logic [AREA_W-1:0]        draw_h = 11'd28;
   logic signed [POS_W-1:0]  org_x = '0;
   logic signed [POS_W-1:0]  org_y = '0;
   logic [AREA_W-1:0]        tgt_w = 11'd288;
   logic [AREA_W-1:0]        tgt_h = 11'd32;

   // Shadow source image and a record of which entries hold loaded data.
   logic [SRC_WORD_W-1:0] src_mem [STORE_DEPTH];
   bit                    src_loaded [STORE_DEPTH];

   // Blended pixels still owed by the block, oldest first.
   blit_pixel_type pixel_q [$];

   int  errors = 0;
   int  items_sent = 0;
   int  n_loads = 0;
   int  n_draws = 0;
   int  n_written = 0;
   int  n_geometries = 0;
   int  n_checked = 0;
   // Chance in percent that either side starts an idle burst; calm turns idling off.
   int  idle_pct = 0;
   bit  calm = 1'b0;
   int  stall_left = 0;

   nearest_scaled_alpha_blit #(
      .SOURCE_PIXELS(STORE_DEPTH),
      .COORD_BITS   (COORD_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The run must never hang: a stuck handshake or a missing result ends here.
   initial begin
      #2_000_000;
      $display("nearest_scaled_alpha_blit: mismatch");
      $finish;
   end

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report($sformatf("result %0d %s: got %0d, expected %0d", n_checked, name, got, want));
   endtask

   // Alpha-over for one channel, truncated: (s*a + d*(255-a)) / 255.
   function automatic logic [PIX_W-1:0] blend(input int s, input int d, input int a);
      return PIX_W'((s * a + d * (int'(PIX_MAX) - a)) / int'(PIX_MAX));
   endfunction

   // Source store address that a draw at (col, row) reads, or -1 when the draw is
   // decided before any read: outside the drawing area, empty source, or clipped.
   function automatic int source_address(input logic [COORD_W-1:0] col,
                                         input logic [COORD_W-1:0] row);
      int tx;
      int ty;
      if (AREA_W'(col) >= draw_w || AREA_W'(row) >= draw_h || src_w == '0 || src_h == '0)
         return -1;
      tx = int'(org_x) + int'(col);
      ty = int'(org_y) + int'(row);
      if (tx < 0 || ty < 0 || tx >= int'(tgt_w) || ty >= int'(tgt_h))
         return -1;
      return (int'(row) * int'(src_h) / int'(draw_h)) * int'(src_w)
             + int'(col) * int'(src_w) / int'(draw_w);
   endfunction

   // Expected response to one draw under the current geometry and source image.
   // An address beyond the store reads as transparent, so nothing is written.
   function automatic blit_pixel_type predict_draw(input blit_req_type it);
      blit_pixel_type p;
      int addr;
      int a;
      logic [SRC_WORD_W-1:0] word;
      p = '0;
      addr = source_address(it.col, it.row);
      if (addr < 0 || addr >= STORE_DEPTH)
         return p;
      word = src_mem[addr];
      a = int'(word[31:24]);
      if (a == 0)
         return p;
      p.wr    = 1'b1;
      p.col   = org_x + POS_W'(it.col);
      p.row   = org_y + POS_W'(it.row);
      p.red   = blend(int'(word[7:0]), int'(it.red), a);
      p.green = blend(int'(word[15:8]), int'(it.green), a);
      p.blue  = blend(int'(word[23:16]), int'(it.blue), a);
      p.alpha = PIX_MAX;
      return p;
   endfunction

   // Transparent, opaque and partial alpha all need plenty of hits.
   function automatic logic [PIX_W-1:0] random_alpha();
      case ($urandom_range(3))
         0: return '0;
         1: return PIX_MAX;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Sends one item and waits for its transfer, then updates the shadow model.
   // The valid line is dropped only for an idle burst, never at the same edge
   // where it is raised again.
   task automatic send_item(input blit_req_type it);
      int gap;
      if (!calm && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {it.alpha, it.blue, it.green, it.red, it.row, it.col, it.index};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (it.op == OP_LOAD) begin
         src_mem[it.index]    = {it.alpha, it.blue, it.green, it.red};
         src_loaded[it.index] = 1'b1;
         n_loads++;
      end else begin
         pixel_q.push_back(predict_draw(it));
         n_draws++;
         if (pixel_q[$].wr)
            n_written++;
      end
   endtask

   task automatic send_load(input int idx, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
      blit_req_type it;
      it = '{op: OP_LOAD, alpha: a, blue: b, green: g, red: r,
             row: COORD_W'($urandom), col: COORD_W'($urandom), index: LOAD_IDX_W'(idx)};
      send_item(it);
   endtask

   task automatic send_random_load(input int idx);
      send_load(idx, 8'($urandom), 8'($urandom), 8'($urandom), random_alpha());
   endtask

   // A draw never reads a store entry that was not loaded: such an entry is
   // loaded with random content right before the draw that needs it.
   task automatic send_draw(input int col, input int row, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
      blit_req_type it;
      int addr;
      addr = source_address(COORD_W'(col), COORD_W'(row));
      if (addr >= 0 && addr < STORE_DEPTH && !src_loaded[addr])
         send_random_load(addr);
      it = '{op: OP_DRAW, alpha: 8'($urandom), blue: b, green: g, red: r,
             row: COORD_W'(row), col: COORD_W'(col), index: LOAD_IDX_W'($urandom)};
      send_item(it);
   endtask

   task automatic send_random_draw(input int col, input int row);
      send_draw(col, row, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Register write; csr_valid stays high so back-to-back writes need no re-raise.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SOURCE_WIDTH:  src_w  = data[SIZE_W-1:0];
         CSR_SOURCE_HEIGHT: src_h  = data[SIZE_W-1:0];
         CSR_DRAW_WIDTH:    draw_w = data[AREA_W-1:0];
         CSR_DRAW_HEIGHT:   draw_h = data[AREA_W-1:0];
         CSR_ORIGIN_X:      org_x  = data;
         CSR_ORIGIN_Y:      org_y  = data;
         CSR_TARGET_WIDTH:  tgt_w  = data[AREA_W-1:0];
         CSR_TARGET_HEIGHT: tgt_h  = data[AREA_W-1:0];
         default: ;
      endcase
   endtask

   // Lets every owed result come out, then waits out the pipeline so that no
   // load is still on its way into the store.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the whole geometry while the block is idle. An index past the
   // register list goes in first and must change nothing.
   task automatic set_geometry(input logic [11:0] sw, input logic [11:0] sh,
                               input logic [11:0] dw, input logic [11:0] dh,
                               input logic [11:0] ox, input logic [11:0] oy,
                               input logic [11:0] tw, input logic [11:0] th);
      wait_drained();
      write_reg(CSR_INDEX_W'(int'(CSR_TARGET_HEIGHT) + 1 + $urandom_range(0, 7)),
                CSR_DATA_W'($urandom));
      write_reg(CSR_SOURCE_WIDTH, sw);
      write_reg(CSR_SOURCE_HEIGHT, sh);
      write_reg(CSR_DRAW_WIDTH, dw);
      write_reg(CSR_DRAW_HEIGHT, dh);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_TARGET_WIDTH, tw);
      write_reg(CSR_TARGET_HEIGHT, th);
      csr_valid <= 1'b0;
      n_geometries++;
   endtask

   // Receiver side: rsp_tready drops for idle bursts, started at random unless calm is set.
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (!calm && $urandom_range(99) < idle_pct)
         stall_left = $urandom_range(1, 4);
      rsp_tready <= !reset && stall_left == 0;
   end

   // Every response transfer is matched against the oldest owed pixel.
   always @(posedge clock) begin
      blit_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            report("response transfer with no draw waiting for it");
         end else begin
            want = pixel_q.pop_front();
            check_field("write_valid", 16'(rsp_tuser), 16'(want.wr));
            check_field("target_col", 16'(rsp_tdata[11:0]), 16'(want.col));
            check_field("target_row", 16'(rsp_tdata[23:12]), 16'(want.row));
            check_field("out_red", 16'(rsp_tdata[31:24]), 16'(want.red));
            check_field("out_green", 16'(rsp_tdata[39:32]), 16'(want.green));
            check_field("out_blue", 16'(rsp_tdata[47:40]), 16'(want.blue));
            check_field("out_alpha", 16'(rsp_tdata[55:48]), 16'(want.alpha));
            n_checked++;
         end
      end
   end

   // Reset geometry: opaque, transparent and nearly transparent sources, the
   // corners of the drawing area and positions just outside it.
   task automatic test_default_geometry();
      idle_pct = 30;
      send_load(0, 8'd255, 8'd0, 8'd255, 8'd255);
      send_draw(0, 0, 8'd0, 8'd255, 8'd0);
      send_load(1, 8'd10, 8'd20, 8'd30, 8'd0);
      send_draw(1, 0, 8'd255, 8'd255, 8'd255);
      send_load(2, 8'd200, 8'd100, 8'd50, 8'd1);
      send_draw(2, 0, 8'd255, 8'd255, 8'd255);
      send_load(4095, 8'd255, 8'd255, 8'd255, 8'd255);
      send_draw(27, 27, 8'd255, 8'd0, 8'd128);
      send_draw(28, 0, 8'd1, 8'd2, 8'd3);
      send_draw(0, 28, 8'd1, 8'd2, 8'd3);
      send_draw(1023, 1023, 8'd255, 8'd255, 8'd255);
   endtask

   // Register extremes: clipping on every side, empty sizes, masked upper
   // register bits, addresses beyond the store and the largest image.
   task automatic test_edge_geometry();
      // Width written with junk above bit 6 reads back as 4; origins at the
      // most negative and most positive values clip everything.
      set_geometry(12'hF84, 12'd2, 12'd8, 12'd2, 12'h800, 12'h7FF, 12'h7FF, 12'h7FF);
      send_random_draw(0, 0);
      send_random_draw(7, 1);
      // One column left of the target: the first column is clipped.
      set_geometry(12'hF84, 12'd2, 12'd8, 12'd2, 12'hFFF, 12'd0, 12'h7FF, 12'h7FF);
      send_random_draw(0, 0);
      send_random_draw(1, 0);
      send_draw(7, 1, 8'd0, 8'd0, 8'd0);
      send_random_draw(8, 0);
      send_random_draw(1023, 1);
      // Empty source, empty drawing area and empty target.
      set_geometry(12'd0, 12'd4, 12'd4, 12'd4, 12'd0, 12'd0, 12'd16, 12'd16);
      send_random_draw(0, 0);
      set_geometry(12'd4, 12'd4, 12'd0, 12'd0, 12'd0, 12'd0, 12'd16, 12'd16);
      send_random_draw(0, 0);
      set_geometry(12'd4, 12'd4, 12'd4, 12'd4, 12'd0, 12'd0, 12'd0, 12'd0);
      send_random_draw(0, 0);
      // Oversized source: the far corner maps past the end of the store.
      set_geometry(12'd127, 12'd127, 12'd2, 12'd2, 12'd0, 12'd0, 12'd64, 12'd64);
      send_random_draw(1, 1);
      send_random_draw(1, 0);
      // Largest legal image and drawing area.
      set_geometry(12'd64, 12'd64, 12'd1024, 12'd1024, 12'hC00, 12'd0, 12'd1024, 12'd1024);
      send_random_draw(1023, 1023);
      set_geometry(12'd64, 12'd64, 12'd1024, 12'd1024, 12'd0, 12'd0, 12'd1024, 12'd1024);
      send_draw(1023, 1023, 8'd255, 8'd255, 8'd255);
      send_random_draw(0, 1023);
   endtask

   // One frame: pick a geometry, load the whole source image when it is small,
   // then mostly draw inside the area with some reloads and random noise.
   task automatic run_frame(input int budget);
      int sw, sh, dw, dh, ox, oy, tw, th;
      int stop_at;
      int pixels;
      int pick;
      case ($urandom_range(9))
         0: begin
            sw = 64; sh = 64;
            dw = $urandom_range(512, 1024); dh = $urandom_range(512, 1024);
            ox = $urandom_range(0, 2048) - 1024; oy = $urandom_range(0, 2048) - 1024;
            tw = 1024; th = 1024;
         end
         1: begin
            sw = $urandom_range(0, 127); sh = $urandom_range(0, 127);
            dw = $urandom_range(0, 2047); dh = $urandom_range(0, 2047);
            ox = $urandom_range(0, 4095) - 2048; oy = $urandom_range(0, 4095) - 2048;
            tw = $urandom_range(0, 2047); th = $urandom_range(0, 2047);
         end
         default: begin
            sw = $urandom_range(1, 8); sh = $urandom_range(1, 8);
            dw = $urandom_range(1, 24); dh = $urandom_range(1, 24);
            ox = $urandom_range(0, 16) - 8; oy = $urandom_range(0, 16) - 8;
            tw = $urandom_range(1, 32); th = $urandom_range(1, 32);
         end
      endcase
      set_geometry(CSR_DATA_W'(sw), CSR_DATA_W'(sh), CSR_DATA_W'(dw), CSR_DATA_W'(dh),
                   CSR_DATA_W'(ox), CSR_DATA_W'(oy), CSR_DATA_W'(tw), CSR_DATA_W'(th));
      case ($urandom_range(2))
         0: idle_pct = 0;
         1: idle_pct = 25;
         default: idle_pct = 60;
      endcase
      stop_at = items_sent + budget;
      pixels = sw * sh;
      if (pixels > STORE_DEPTH)
         pixels = STORE_DEPTH;
      if (pixels <= 256)
         for (int i = 0; i < pixels; i++)
            send_random_load(i);
      while (items_sent < stop_at) begin
         pick = $urandom_range(9);
         if (pick < 7)
            send_random_draw($urandom_range(0, (dw + 1 > 1023) ? 1023 : dw + 1),
                             $urandom_range(0, (dh + 1 > 1023) ? 1023 : dh + 1));
         else if (pick == 7 && pixels > 0)
            send_random_load($urandom_range(0, pixels - 1));
         else if (pick == 8)
            send_random_draw($urandom_range(0, 1023), $urandom_range(0, 1023));
         else
            send_random_load($urandom_range(0, STORE_DEPTH - 1));
      end
   endtask

   task automatic test_scaled_frames(input int limit, input bit quiet);
      calm = quiet;
      while (items_sent < limit)
         run_frame($urandom_range(60, 160));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_geometry();
      test_edge_geometry();
      test_scaled_frames(ITEM_TARGET - 200, 1'b0);
      // Closing frames run with both sides always ready.
      test_scaled_frames(ITEM_TARGET, 1'b1);
      wait_drained();
      $display("Sent %0d loads and %0d draws across %0d geometries.",
               n_loads, n_draws, n_geometries);
      $display("Checked %0d responses, %0d of them blended writes.", n_checked, n_written);
      if (errors == 0) begin
         $display("nearest_scaled_alpha_blit: match");
      end else begin
         $display("nearest_scaled_alpha_blit: mismatch");
      end
      $finish;
   end

endmodule
